FILE: design/skr_pkg.sv
// Shared types, constants and cell functions for the SKINNY-64 round engine.
`default_nettype none
package skr_pkg;

   localparam int unsigned CellW  = 4;
   localparam int unsigned NCells = 16;
   localparam int unsigned StateW = CellW * NCells;

   typedef logic [CellW-1:0]  cell_type;
   typedef logic [StateW-1:0] state_type;

   // Request kinds carried in the action bit.
   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_ROUND = 1'b1
   } action_type;

   localparam cell_type SBOX [NCells] = '{
      4'd12, 4'd6, 4'd9, 4'd0, 4'd1, 4'd10, 4'd2, 4'd11,
      4'd3, 4'd8, 4'd5, 4'd13, 4'd4, 4'd14, 4'd7, 4'd15
   };

   // New cell k takes old cell PERM[k].
   localparam cell_type PERM [NCells] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
      4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
   };

   function automatic cell_type sub_cell(input cell_type c);
      return SBOX[c];
   endfunction

endpackage : skr_pkg
`default_nettype wire

FILE: design/skr_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none
interface skr_req_if;
   import skr_pkg::*;
   logic      valid;
   logic      ready;
   logic      action;
   state_type value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface : skr_req_if

interface skr_rsp_if;
   import skr_pkg::*;
   logic      valid;
   logic      ready;
   state_type state_out;

   modport source (output valid, output state_out, input ready);
   modport sink   (input valid, input state_out, output ready);
endinterface : skr_rsp_if
`default_nettype wire

FILE: design/skinny64_round_engine_top.sv
// Top level of the SKINNY-64 round engine: state register, round logic, output buffer.
// Usage:
//  - req_chan (sink): valid/ready with action and a 64-bit value. action=0 loads
//    value as the new cipher state, action=1 runs one keyed round with value as
//    the round key. Cell k of state and key sits at bits 4k+3..4k.
//  - rsp_chan (source): one response per request carrying the state after it.
//  - Response: the updated state is registered into the output buffer on acceptance.
//  - Throughput: one request per cycle while req_chan.ready is high. The round
//    is a single pass of S-box, XOR and wiring between the state register and
//    the output register, so chained rounds run back to back.
//  - Stall: a two-entry output buffer (head plus skid) keeps accepting while one
//    response waits; req_chan.ready drops only when both entries are full.
//  - Reset (synchronous, active high): state cleared to zero, output buffer
//    emptied. No responses are lost or duplicated across a stall.
`default_nettype none
module skinny64_round_engine_top
   import skr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   skr_req_if.sink   req_chan,
   skr_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;
   state_type round_out;
   logic      req_fire;
   logic      buf_ready;

   // Round on the current state keyed by the request value.
   skr_round u_round (
      .state_i (state_ff),
      .key_i   (req_chan.value),
      .state_o (round_out)
   );

   assign req_chan.ready = buf_ready;
   assign req_fire       = req_chan.valid && buf_ready;

   // Next state: load or round, taken only on an accepted request.
   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         unique case (action_type'(req_chan.action))
            ACT_LOAD:  state_in = req_chan.value;
            ACT_ROUND: state_in = round_out;
            default:   state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response equals the updated state; buffered so stalls do not block input.
   skr_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_fire),
      .push_data  (state_in),
      .push_ready (buf_ready),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTH
   a_state_holds_idle : assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> state_ff == $past(state_ff))
      else $error("state changed without an accepted request");

   a_load_takes_value : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.action == ACT_LOAD) |=> state_ff == $past(req_chan.value))
      else $error("load did not capture the request value");

   a_rsp_after_fire : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid)
      else $error("no response pending after accepted request");
`endif

endmodule : skinny64_round_engine_top
`default_nettype wire

FILE: design/skr_round.sv
// One keyed round: S-box, key XOR, ShiftRows, binary MixColumns.
`default_nettype none
module skr_round
   import skr_pkg::*;
(
   input  state_type state_i,
   input  state_type key_i,
   output state_type state_o
);

   cell_type sk [NCells];
   cell_type sr [NCells];

   always_comb begin
      for (int k = 0; k < NCells; k++) begin
         sk[k] = sub_cell(state_i[k*CellW +: CellW]) ^ key_i[k*CellW +: CellW];
      end
      for (int k = 0; k < NCells; k++) begin
         sr[k] = sk[PERM[k]];
      end
   end

   // Column mix per column: rows 0..3 hold a0..a3.
   for (genvar col = 0; col < 4; col++) begin : g_mix
      cell_type a0, a1, a2, a3;
      cell_type m1, m2, m3;
      assign a0 = sr[col];
      assign a1 = sr[4 + col];
      assign a2 = sr[8 + col];
      assign a3 = sr[12 + col];
      assign m1 = a1 ^ a2;
      assign m2 = a2 ^ a0;
      assign m3 = a3 ^ m2;
      assign state_o[col*CellW +: CellW]        = m3;
      assign state_o[(4 + col)*CellW +: CellW]  = a0;
      assign state_o[(8 + col)*CellW +: CellW]  = m1;
      assign state_o[(12 + col)*CellW +: CellW] = m2;
   end

endmodule : skr_round
`default_nettype wire

FILE: design/skr_outbuf.sv
// Two-entry output register with skid slot for the response channel.
`default_nettype none
module skr_outbuf
   import skr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  state_type push_data,
   output logic      push_ready,
   skr_rsp_if.source rsp_chan
);

   logic      out_valid_ff, out_valid_in;
   state_type out_data_ff, out_data_in;
   logic      skid_valid_ff, skid_valid_in;
   state_type skid_data_ff, skid_data_in;
   logic      pop, out_free;

   assign push_ready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_chan.ready;
   assign out_free   = !out_valid_ff || pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push_valid;
            out_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.state_out = out_data_ff;

`ifndef SYNTH
   a_skid_needs_head : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot occupied while head is empty");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_valid)
      else $error("push into full output buffer");

   a_skid_drains_next : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && out_data_ff == $past(skid_data_ff)))
      else $error("skid entry not moved to head after pop");
`endif

endmodule : skr_outbuf
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the SKINNY-64 round engine: directed and random requests.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import skr_pkg::*;

   // Cycles without any handshake before the run is declared hung. The slowest
   // legal stretch (85% sender idle or 85% receiver stall) never comes close.
   localparam int STALL_LIMIT = 5000;
   // Cap on detailed mismatch lines so a broken block does not flood the log.
   localparam int MAX_REPORTS = 20;
   // Random requests per idle phase; four phases plus the directed set make ~1050.
   localparam int PHASE_ITEMS = 257;

   // 4-bit S-box, indexed by the input cell value.
   localparam cell_type SUBST_TABLE [16] = '{
      4'd12, 4'd6, 4'd9, 4'd0, 4'd1, 4'd10, 4'd2, 4'd11,
      4'd3, 4'd8, 4'd5, 4'd13, 4'd4, 4'd14, 4'd7, 4'd15
   };
   // ShiftRows: new cell k is taken from old cell ROW_SHIFT_SRC[k].
   localparam cell_type ROW_SHIFT_SRC [16] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
      4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
   };

   // Tracks the cipher state as the block should hold it and keeps the
   // states still owed on the response channel, oldest first.
   class state_tracker;
      state_type tracked_state;
      state_type expected_states[$];
      int        loads;
      int        rounds;
      int        checked;
      int        mismatches;

      function new();
         tracked_state = '0;
         loads = 0;
         rounds = 0;
         checked = 0;
         mismatches = 0;
      endfunction

      // One keyed round: S-box, key XOR, ShiftRows, binary MixColumns.
      function state_type keyed_round(state_type s, state_type key);
         cell_type  mixed [16];
         cell_type  shifted [16];
         cell_type  a0, a1, a2, a3;
         state_type r;
         for (int k = 0; k < 16; k++)
            mixed[k] = SUBST_TABLE[s[4*k +: 4]] ^ key[4*k +: 4];
         for (int k = 0; k < 16; k++)
            shifted[k] = mixed[ROW_SHIFT_SRC[k]];
         for (int col = 0; col < 4; col++) begin
            a0 = shifted[col];
            a1 = shifted[4 + col];
            a2 = shifted[8 + col];
            a3 = shifted[12 + col];
            a1 = a1 ^ a2;
            a2 = a2 ^ a0;
            a3 = a3 ^ a2;
            shifted[col]      = a3;
            shifted[4 + col]  = a0;
            shifted[8 + col]  = a1;
            shifted[12 + col] = a2;
         end
         r = '0;
         for (int k = 0; k < 16; k++)
            r[4*k +: 4] = shifted[k];
         return r;
      endfunction

      function void note_request(action_type act, state_type val);
         if (act == ACT_LOAD) begin
            tracked_state = val;
            loads++;
         end else begin
            tracked_state = keyed_round(tracked_state, val);
            rounds++;
         end
         expected_states.push_back(tracked_state);
      endfunction

      function void check_response(state_type got);
         state_type want;
         if (expected_states.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response, expected none, actual %016h", $time, got);
            return;
         end
         want = expected_states.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: state_out mismatch, expected %016h, actual %016h",
                        $time, want, got);
         end
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   skr_req_if req_bus ();
   skr_rsp_if rsp_bus ();

   skinny64_round_engine_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   state_tracker sb;

   // Idle knobs, in percent; changed per phase by the main sequence.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   bit progress;

   always #2 clock = ~clock;

   // Receiver side: ready is redrawn every falling edge from the stall knob.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor and watchdog. Both handshakes are sampled at the rising edge;
   // the request is noted before the response is checked, though a response
   // never belongs to the request accepted on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(action_type'(req_bus.action), req_bus.value);
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.state_out);
            progress = 1'b1;
         end
         if (progress)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic state_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Drive one request. Entered and left at a falling edge; holds valid
   // until the block takes the request, with optional idle cycles ahead of it.
   task automatic send_request(action_type act, state_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.action <= 1'($urandom_range(1));
         req_bus.value <= rand_word();
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Edge patterns: loads of both extremes and of every cell value, rounds
   // chained on the reset state and on loaded states, keys at both extremes.
   task automatic run_directed();
      send_request(ACT_ROUND, '0);        // round straight from the reset state
      send_request(ACT_ROUND, '1);
      send_request(ACT_LOAD,  '1);
      send_request(ACT_ROUND, '0);
      send_request(ACT_ROUND, '1);
      send_request(ACT_LOAD,  64'hFEDC_BA98_7654_3210);  // every S-box input once
      send_request(ACT_ROUND, '0);
      send_request(ACT_ROUND, 64'h0123_4567_89AB_CDEF);
      send_request(ACT_LOAD,  64'hAAAA_AAAA_AAAA_AAAA);
      send_request(ACT_ROUND, 64'h5555_5555_5555_5555);
      send_request(ACT_LOAD,  64'h5555_5555_5555_5555);
      send_request(ACT_ROUND, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(ACT_LOAD,  '0);
      send_request(ACT_ROUND, '0);
      send_request(ACT_ROUND, '0);
      send_request(ACT_ROUND, '0);
      send_request(ACT_LOAD,  64'h8000_0000_0000_0001);
      send_request(ACT_ROUND, 64'h8000_0000_0000_0001);
      send_request(ACT_LOAD,  64'h0F0F_0F0F_0F0F_0F0F);
      send_request(ACT_ROUND, 64'hF0F0_F0F0_F0F0_F0F0);
      send_request(ACT_LOAD,  64'h0123_4567_89AB_CDEF);
      send_request(ACT_ROUND, 64'hFEDC_BA98_7654_3210);
   endtask

   // Mostly chained rounds so the state wanders far from any load; loads
   // and extreme keys are mixed in.
   task automatic run_random(int count);
      int        pick;
      state_type val;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         val = rand_word();
         if ($urandom_range(19) == 0)
            val = $urandom_range(1) ? '1 : '0;
         send_request((pick < 20) ? ACT_LOAD : ACT_ROUND, val);
      end
   endtask

   initial begin
      // All block inputs known from time zero; reset held high at the start.
      reset = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed set with both sides streaming.
      run_directed();

      // Random phases: no idling, sender idle, receiver stalling, both.
      send_idle_pct = 0;   recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
      send_idle_pct = 85;  recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
      send_idle_pct = 0;   recv_stall_pct = 85;
      run_random(PHASE_ITEMS);
      send_idle_pct = 23;  recv_stall_pct = 23;
      run_random(PHASE_ITEMS);

      // Drain, then a few cycles for any stray response to show up.
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Run covered %0d loads and %0d rounds; %0d responses compared.",
               sb.loads, sb.rounds, sb.checked);
      $display("Phases: directed edge cases, then random with no idling, sender idle, "
               , "receiver stall and both idling.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : testbench
`default_nettype wire

FILE: files.f
design/skr_pkg.sv
design/skr_ifs.sv
design/skr_round.sv
design/skr_outbuf.sv
design/skinny64_round_engine_top.sv
sim/testbench.sv
